>>> sv/bsm_pkg.sv
// Package for the battery state-of-charge monitor.
// Field widths, register indexes, reset values and the controller state type.
// No dependencies.
`default_nettype none

package bsm_pkg;

   localparam int unsigned SAMPLE_W   = 16;
   localparam int unsigned VOLT_W     = 10;
   localparam int unsigned SOC_W      = 7;
   localparam int unsigned FLOOR_W    = 17;
   localparam int unsigned RSP_W      = SAMPLE_W + SOC_W + 1;

   localparam int unsigned DEPTH_DEF  = 16;
   localparam int unsigned PCT_SCALE  = 100;
   localparam int unsigned SOC_FULL   = 100;
   localparam int unsigned TRANS_MULT = 10;
   localparam int unsigned STEP_DIV   = 4;
   localparam int unsigned SAMPLE_MAX = 65535;

   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = VOLT_W;

   localparam logic [VOLT_W-1:0] MIN_VOLTS_RST = VOLT_W'(30);
   localparam logic [VOLT_W-1:0] MAX_VOLTS_RST = VOLT_W'(42);
   localparam logic [SOC_W-1:0]  LOW_THR_RST   = SOC_W'(10);
   localparam logic [SOC_W-1:0]  RECH_THR_RST  = SOC_W'(20);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_VOLTS = 2'd0,
      CSR_MAX_VOLTS = 2'd1,
      CSR_LOW_THR   = 2'd2,
      CSR_RECH_THR  = 2'd3
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AVG,
      ST_DIVA_GO,
      ST_DIVA,
      ST_DIVS_GO,
      ST_DIVS,
      ST_PUSH
   } state_type;

endpackage

`default_nettype wire

>>> sv/bsm_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Uses no package items; shared by the average and the charge division.
`default_nettype none

module bsm_div #(
   parameter int unsigned NW  = 20,
   parameter int unsigned DVW = 10
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic [NW-1:0]  dividend,
   input  wire logic [DVW-1:0] divisor,
   output logic                done,
   output logic [NW-1:0]       quotient
);

   localparam int unsigned CNT_W = $clog2(NW + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [NW-1:0]     quo_ff, quo_in;
   logic [DVW-1:0]    rem_ff, rem_in;
   logic [DVW-1:0]    dvs_ff, dvs_in;
   logic [DVW:0]      shifted;
   logic [DVW:0]      trial;
   logic              ge;

   assign shifted = {rem_ff, quo_ff[NW-1]};
   assign ge      = shifted >= {1'b0, dvs_ff};
   assign trial   = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NW);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NW-2:0], ge};
         rem_in = ge ? trial[DVW-1:0] : shifted[DVW-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

>>> sv/bsm_avg.sv
// Sample ring and running sum for the moving average.
// Depends on bsm_pkg for the sample width.
`default_nettype none

module bsm_avg
   import bsm_pkg::*;
#(
   parameter int unsigned DEPTH = DEPTH_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic [SAMPLE_W-1:0]                   sample,
   output logic                                       done,
   output logic [SAMPLE_W+$clog2(DEPTH)-1:0]          sum,
   output logic [$clog2(DEPTH+1)-1:0]                 count,
   output logic                                       filled
);

   localparam int unsigned IW = $clog2(DEPTH);
   localparam int unsigned SW = SAMPLE_W + IW;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [SAMPLE_W-1:0] ring_mem [DEPTH];

   logic                stage_ff, done_ff;
   logic [IW-1:0]       idx_ff, idx_in;
   logic                filled_ff, filled_in;
   logic [SW-1:0]       sum_ff, sum_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [SAMPLE_W-1:0] sample_ff;
   logic [SAMPLE_W-1:0] old_ff;
   logic                last_slot;

   assign last_slot = idx_ff == IW'(DEPTH - 1);

   always_comb begin
      idx_in    = idx_ff;
      filled_in = filled_ff;
      sum_in    = sum_ff;
      count_in  = count_ff;
      if (stage_ff) begin
         sum_in   = (filled_ff ? sum_ff - SW'(old_ff) : sum_ff) + SW'(sample_ff);
         count_in = filled_ff ? CW'(DEPTH) : CW'(idx_ff) + CW'(1);
         idx_in   = last_slot ? '0 : idx_ff + IW'(1);
         if (last_slot) begin
            filled_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff  <= 1'b0;
         done_ff   <= 1'b0;
         idx_ff    <= '0;
         filled_ff <= 1'b0;
         sum_ff    <= '0;
         count_ff  <= '0;
      end else begin
         stage_ff  <= start;
         done_ff   <= stage_ff;
         idx_ff    <= idx_in;
         filled_ff <= filled_in;
         sum_ff    <= sum_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         sample_ff <= sample;
         old_ff    <= ring_mem[idx_ff];
      end
      if (stage_ff) begin
         ring_mem[idx_ff] <= sample_ff;
      end
   end

   assign done   = done_ff;
   assign sum    = sum_ff;
   assign count  = count_ff;
   assign filled = filled_ff;

endmodule

`default_nettype wire

>>> sv/battery_soc_monitor.sv
// Battery state-of-charge monitor, top level: control sequencer, charge rules, ports.
// Depends on bsm_pkg, bsm_avg and bsm_div.
//
// One voltage sample in, one result out. The one bit-serial divider runs the
// average division and then the charge division, one quotient bit a cycle. A
// new sample is taken once the previous one is done; a finished result waits in
// the output register and the next sample may transfer meanwhile. The result
// carries the average clamped up to min_volts*100 (saturated at 65535), the
// accepted charge and the low-battery flag. Charge changes are adopted at once
// until the ring has filled, then only after 10*DEPTH disagreeing samples net of
// DEPTH/4 credit per agreeing sample.
`default_nettype none

module battery_soc_monitor
   import bsm_pkg::*;
#(
   parameter int unsigned DEPTH = DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [SAMPLE_W-1:0]   req_tdata,   // [15:0] voltage_sample
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_W-1:0]           rsp_tdata,   // [15:0] average_voltage,
                                                   // [22:16] charge_percent, [23] low_battery
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned IW        = $clog2(DEPTH);
   localparam int unsigned SW        = SAMPLE_W + IW;
   localparam int unsigned CW        = $clog2(DEPTH + 1);
   localparam int unsigned DVW       = (CW > VOLT_W) ? CW : VOLT_W;
   localparam int unsigned TRANS_LIM = TRANS_MULT * DEPTH;
   localparam int unsigned TW        = $clog2(TRANS_LIM + 1);
   localparam int unsigned STEP      = DEPTH / STEP_DIV;

   state_type            state_ff, state_in;

   logic [VOLT_W-1:0]    min_ff, max_ff;
   logic [SOC_W-1:0]     low_thr_ff, rech_thr_ff;

   logic [FLOOR_W-1:0]   avg_cl_ff, avg_cl_in;
   logic [SAMPLE_W-1:0]  diff_ff, diff_in;
   logic [SOC_W-1:0]     soc_ff, soc_in;
   logic [SOC_W-1:0]     acc_ff, acc_in;
   logic [TW-1:0]        trans_ff, trans_in;
   logic                 low_ff, low_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]     rsp_data_ff, rsp_data_in;

   logic                 avg_start, avg_done, ring_filled;
   logic [SW-1:0]        avg_sum;
   logic [CW-1:0]        avg_count;

   logic                 div_start, div_sel_soc, div_done;
   logic [SW-1:0]        div_dividend, div_quo;
   logic [DVW-1:0]       div_divisor;

   logic                 cap_avg, cap_soc, push, out_free;
   logic [FLOOR_W-1:0]   floor_cv, avg_ext, avg_cl;
   logic [TW-1:0]        trans_inc;
   logic [SAMPLE_W-1:0]  avg_sat;

   bsm_avg #(
      .DEPTH (DEPTH)
   ) u_avg (
      .clock  (clock),
      .reset  (reset),
      .start  (avg_start),
      .sample (req_tdata),
      .done   (avg_done),
      .sum    (avg_sum),
      .count  (avg_count),
      .filled (ring_filled)
   );

   assign div_dividend = div_sel_soc ? SW'(diff_ff) : avg_sum;
   assign div_divisor  = div_sel_soc ? DVW'(max_ff - min_ff) : DVW'(avg_count);

   bsm_div #(
      .NW  (SW),
      .DVW (DVW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff      <= MIN_VOLTS_RST;
         max_ff      <= MAX_VOLTS_RST;
         low_thr_ff  <= LOW_THR_RST;
         rech_thr_ff <= RECH_THR_RST;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_MIN_VOLTS: min_ff      <= csr_wdata[VOLT_W-1:0];
            CSR_MAX_VOLTS: max_ff      <= csr_wdata[VOLT_W-1:0];
            CSR_LOW_THR:   low_thr_ff  <= csr_wdata[SOC_W-1:0];
            CSR_RECH_THR:  rech_thr_ff <= csr_wdata[SOC_W-1:0];
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_tvalid) state_in = ST_AVG;
         ST_AVG:     if (avg_done) state_in = ST_DIVA_GO;
         ST_DIVA_GO: state_in = ST_DIVA;
         ST_DIVA:    if (div_done) state_in = ST_DIVS_GO;
         ST_DIVS_GO: state_in = ST_DIVS;
         ST_DIVS:    if (div_done) state_in = ST_PUSH;
         ST_PUSH:    if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready  = 1'b0;
      avg_start   = 1'b0;
      div_start   = 1'b0;
      div_sel_soc = 1'b0;
      cap_avg     = 1'b0;
      cap_soc     = 1'b0;
      push        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            avg_start  = req_tvalid;
         end
         ST_AVG: ;
         ST_DIVA_GO: div_start = 1'b1;
         ST_DIVA: cap_avg = div_done;
         ST_DIVS_GO: begin
            div_start   = 1'b1;
            div_sel_soc = 1'b1;
         end
         ST_DIVS: cap_soc = div_done;
         ST_PUSH: push = out_free;
         default: ;
      endcase
   end

   // clamp and charge mapping
   assign floor_cv = FLOOR_W'(min_ff) * FLOOR_W'(PCT_SCALE);
   assign avg_ext  = FLOOR_W'(div_quo[SAMPLE_W-1:0]);
   assign avg_cl   = (avg_ext < floor_cv) ? floor_cv : avg_ext;
   assign avg_sat  = (avg_cl_ff > FLOOR_W'(SAMPLE_MAX)) ? SAMPLE_W'(SAMPLE_MAX)
                                                       : avg_cl_ff[SAMPLE_W-1:0];
   assign trans_inc = trans_ff + TW'(1);

   always_comb begin
      avg_cl_in    = avg_cl_ff;
      diff_in      = diff_ff;
      soc_in       = soc_ff;
      acc_in       = acc_ff;
      trans_in     = trans_ff;
      low_in       = low_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (cap_avg) begin
         avg_cl_in = avg_cl;
         diff_in   = SAMPLE_W'(avg_cl - floor_cv);
      end
      if (cap_soc) begin
         if (max_ff <= min_ff) begin
            soc_in = '0;
         end else if (div_quo > SW'(SOC_FULL)) begin
            soc_in = SOC_W'(SOC_FULL);
         end else begin
            soc_in = div_quo[SOC_W-1:0];
         end
      end
      if (push) begin
         if (soc_ff != acc_ff) begin
            if ((trans_inc >= TW'(TRANS_LIM)) || !ring_filled) begin
               trans_in = '0;
               acc_in   = soc_ff;
            end else begin
               trans_in = trans_inc;
            end
         end else begin
            trans_in = (trans_ff > TW'(STEP)) ? trans_ff - TW'(STEP) : '0;
         end
         priority if ((acc_in <= low_thr_ff) && !low_ff) begin
            low_in = 1'b1;
         end else if ((acc_in >= rech_thr_ff) && low_ff) begin
            low_in = 1'b0;
         end
         rsp_valid_in = 1'b1;
         rsp_data_in  = {low_in, acc_in, avg_sat};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         trans_ff     <= '0;
         low_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         trans_ff     <= trans_in;
         low_ff       <= low_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      avg_cl_ff   <= avg_cl_in;
      diff_ff     <= diff_in;
      soc_ff      <= soc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_charge_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_W-2:SAMPLE_W] <= SOC_W'(SOC_FULL))
      else $error("charge above full scale");

   a_trans_bound: assert property (@(posedge clock) disable iff (reset)
      trans_ff < TW'(TRANS_LIM))
      else $error("transition counter past its limit");

   a_first_pass: assert property (@(posedge clock) disable iff (reset)
      !ring_filled |-> trans_ff == '0)
      else $error("transition counter moved during first pass");

endmodule

`default_nettype wire
